// ===== design/sot_pkg.sv =====
package sot_pkg;

   localparam logic       SHAPE_BOX        = 1'b0;
   localparam logic       SHAPE_CIRCLE     = 1'b1;

   localparam logic [1:0] STATUS_INACTIVE  = 2'd0;
   localparam logic [1:0] STATUS_MOVABLE   = 2'd1;
   localparam logic [1:0] STATUS_IMMOVABLE = 2'd2;

   // Distances and limits at double scale are carried as 32-bit magnitudes.
   localparam int MAG_WIDTH  = 32;
   localparam int PROD_WIDTH = 2 * MAG_WIDTH;

   typedef struct packed {
      logic               a_shape;
      logic [1:0]         a_status;
      logic signed [31:0] a_center_x;
      logic signed [31:0] a_center_y;
      logic [30:0]        a_size_x;
      logic [30:0]        a_size_y;
      logic               b_shape;
      logic [1:0]         b_status;
      logic signed [31:0] b_center_x;
      logic signed [31:0] b_center_y;
      logic [30:0]        b_size_x;
      logic [30:0]        b_size_y;
   } req_type;

   typedef struct packed {
      logic overlap;
   } rsp_type;

   // Result of the geometry stage: either the answer is already known, or a
   // squared distance has still to be compared with a squared limit.
   typedef struct packed {
      logic                 decided;
      logic                 hit;
      logic [MAG_WIDTH-1:0] mag_x;
      logic [MAG_WIDTH-1:0] mag_y;
      logic [MAG_WIDTH-1:0] limit;
   } geom_type;

endpackage

// ===== design/sot_stream_if.sv =====
interface sot_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/shape_overlap_test_2d_core.sv =====
// Overlap test for a pair of 2D bodies (box or circle), one flag per pair.
//
// req_chan carries one transaction per body pair: shape, status, centre and
// size of both bodies in Q16.16. rsp_chan returns one transaction per pair
// with the overlap flag, in the order the pairs arrived. Both channels use a
// valid/ready handshake; a transaction moves when valid and ready are high at
// a rising clock edge.
//
// The block is a four-stage pipeline: input register, geometry (bounds,
// clamping, distance components), squaring (three 32 x 32 multipliers) and
// the final sum-and-compare into the result register. Throughput is one pair
// per cycle while the receiver does not stall. Each stage moves on whenever
// the stage after it is empty or moving, so up to four pairs are in flight
// and bubbles are squeezed out.
//
// When the receiver stalls, the result register holds and the pipeline fills
// behind it; req_chan.ready falls only once all four stages are occupied.
// Reset (synchronous, active high) empties the pipeline; data registers are not reset.
module shape_overlap_test_2d_core (
   input logic   clock,
   input logic   reset,
   sot_stream_if.sink   req_chan,
   sot_stream_if.source rsp_chan
);
   import sot_pkg::*;

   typedef struct packed {
      logic                  decided;
      logic                  hit;
      logic [PROD_WIDTH-1:0] sq_x;
      logic [PROD_WIDTH-1:0] sq_y;
      logic [PROD_WIDTH-1:0] sq_limit;
   } prod_type;

   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   logic     geo_valid_ff, geo_valid_in;
   geom_type geo_ff, geo_in;
   logic     prod_valid_ff, prod_valid_in;
   prod_type prod_ff, prod_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_overlap_ff, rsp_overlap_in;

   logic     s1_free, s2_free, s3_free, s4_free;
   logic [PROD_WIDTH:0] dist_sq;

   sot_geom u_geom (
      .pair (in_data_ff),
      .geom (geo_in)
   );

   always_comb begin
      s4_free = !rsp_valid_ff || rsp_chan.ready;
      s3_free = !prod_valid_ff || s4_free;
      s2_free = !geo_valid_ff || s3_free;
      s1_free = !in_valid_ff || s2_free;

      in_valid_in   = s1_free ? req_chan.valid : in_valid_ff;
      geo_valid_in  = s2_free ? in_valid_ff : geo_valid_ff;
      prod_valid_in = s3_free ? geo_valid_ff : prod_valid_ff;
      rsp_valid_in  = s4_free ? prod_valid_ff : rsp_valid_ff;

      prod_in.decided  = geo_ff.decided;
      prod_in.hit      = geo_ff.hit;
      prod_in.sq_x     = PROD_WIDTH'(geo_ff.mag_x * geo_ff.mag_x);
      prod_in.sq_y     = PROD_WIDTH'(geo_ff.mag_y * geo_ff.mag_y);
      prod_in.sq_limit = PROD_WIDTH'(geo_ff.limit * geo_ff.limit);

      // Only a strictly smaller squared distance counts as a collision.
      dist_sq        = {1'b0, prod_ff.sq_x} + {1'b0, prod_ff.sq_y};
      rsp_overlap_in = prod_ff.decided ? prod_ff.hit : (dist_sq < {1'b0, prod_ff.sq_limit});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         geo_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         geo_valid_ff  <= geo_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         in_data_ff <= req_chan.data;
      end
      if (s2_free) begin
         geo_ff <= geo_in;
      end
      if (s3_free) begin
         prod_ff <= prod_in;
      end
      if (s4_free) begin
         rsp_overlap_ff <= rsp_overlap_in;
      end
   end

   assign req_chan.ready       = s1_free;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.data.overlap = rsp_overlap_ff;

   // With every stage full and the receiver stalled, no new transaction may enter.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && geo_valid_ff && prod_valid_ff && rsp_valid_ff && !rsp_chan.ready)
      |-> !req_chan.ready)
      else $error("input accepted while the pipeline is full and stalled");

   // A pair with an inactive body is settled as a miss in the geometry stage.
   a_inactive_miss: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && s2_free &&
       (in_data_ff.a_status == STATUS_INACTIVE || in_data_ff.b_status == STATUS_INACTIVE))
      |=> (geo_valid_ff && geo_ff.decided && !geo_ff.hit))
      else $error("inactive body not settled as a miss");

   // Two immovable bodies never collide.
   a_immovable_miss: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && s2_free &&
       in_data_ff.a_status == STATUS_IMMOVABLE && in_data_ff.b_status == STATUS_IMMOVABLE)
      |=> (geo_valid_ff && geo_ff.decided && !geo_ff.hit))
      else $error("two immovable bodies reported as colliding");

endmodule

// ===== design/sot_geom.sv =====
module sot_geom (
   input  sot_pkg::req_type  pair,
   output sot_pkg::geom_type geom
);
   import sot_pkg::*;

   // All coordinates at double scale: centre times two, full size as the half extent.
   logic signed [34:0] acx, acy, bcx, bcy;
   logic signed [34:0] asx, asy, bsx, bsy;
   logic               a_active, b_active, kill;
   logic               box_box, circ_circ, box_hit;
   logic signed [34:0] kx, ky, kw, kh, cx, cy;
   logic [30:0]        cd;
   logic signed [34:0] lo_dx, hi_dx, lo_dy, hi_dy;
   logic signed [34:0] clamp_dx, clamp_dy;
   logic signed [34:0] dx, dy;
   logic [33:0]        ux, uy;
   logic [31:0]        limit;
   logic               far;

   always_comb begin
      acx = {{2{pair.a_center_x[31]}}, pair.a_center_x, 1'b0};
      acy = {{2{pair.a_center_y[31]}}, pair.a_center_y, 1'b0};
      bcx = {{2{pair.b_center_x[31]}}, pair.b_center_x, 1'b0};
      bcy = {{2{pair.b_center_y[31]}}, pair.b_center_y, 1'b0};
      asx = {4'b0, pair.a_size_x};
      asy = {4'b0, pair.a_size_y};
      bsx = {4'b0, pair.b_size_x};
      bsy = {4'b0, pair.b_size_y};

      a_active = (pair.a_status == STATUS_MOVABLE) || (pair.a_status == STATUS_IMMOVABLE);
      b_active = (pair.b_status == STATUS_MOVABLE) || (pair.b_status == STATUS_IMMOVABLE);
      kill     = !a_active || !b_active ||
                 ((pair.a_status == STATUS_IMMOVABLE) && (pair.b_status == STATUS_IMMOVABLE));

      box_box   = (pair.a_shape == SHAPE_BOX) && (pair.b_shape == SHAPE_BOX);
      circ_circ = (pair.a_shape == SHAPE_CIRCLE) && (pair.b_shape == SHAPE_CIRCLE);

      // Touching intervals count as overlap.
      box_hit = !((acx + asx < bcx - bsx) || (acx - asx > bcx + bsx) ||
                  (acy + asy < bcy - bsy) || (acy - asy > bcy + bsy));

      if (pair.a_shape == SHAPE_BOX) begin
         kx = acx; ky = acy; kw = asx; kh = asy; cx = bcx; cy = bcy; cd = pair.b_size_x;
      end else begin
         kx = bcx; ky = bcy; kw = bsx; kh = bsy; cx = acx; cy = acy; cd = pair.a_size_x;
      end

      // Offset from the circle centre to its nearest point inside the box.
      lo_dx = kx - kw - cx;
      hi_dx = kx + kw - cx;
      lo_dy = ky - kh - cy;
      hi_dy = ky + kh - cy;
      if (lo_dx > 35'sd0) begin
         clamp_dx = lo_dx;
      end else if (hi_dx < 35'sd0) begin
         clamp_dx = hi_dx;
      end else begin
         clamp_dx = '0;
      end
      if (lo_dy > 35'sd0) begin
         clamp_dy = lo_dy;
      end else if (hi_dy < 35'sd0) begin
         clamp_dy = hi_dy;
      end else begin
         clamp_dy = '0;
      end

      if (circ_circ) begin
         dx    = acx - bcx;
         dy    = acy - bcy;
         limit = 32'(asx + bsx);
      end else begin
         dx    = clamp_dx;
         dy    = clamp_dy;
         limit = {1'b0, cd};
      end

      ux = dx[34] ? 34'(-dx) : dx[33:0];
      uy = dy[34] ? 34'(-dy) : dy[33:0];

      // The limit is below 2^32, so a component of 2^32 or more can never be inside it.
      far = (ux[33:32] != 2'b00) || (uy[33:32] != 2'b00);

      geom.decided = kill || box_box || far;
      geom.hit     = !kill && box_box && box_hit;
      geom.mag_x   = ux[31:0];
      geom.mag_y   = uy[31:0];
      geom.limit   = limit;
   end

endmodule
